[rtl/notification_led_priority_mixer_core_macros.svh]
// assertion macros for the notification led priority mixer checker
// used by nlpm_checker, expects clk_i and rst_ni in scope
`ifndef NOTIFICATION_LED_PRIORITY_MIXER_CORE_MACROS_SVH
`define NOTIFICATION_LED_PRIORITY_MIXER_CORE_MACROS_SVH

// checked outside reset
`define NLPM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// checked on every edge, reset included
`define NLPM_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

[rtl/nlpm_pkg.sv]
// shared types and constants of the notification led priority mixer
// no dependencies, imported by every module of the block
package nlpm_pkg;

  localparam int unsigned CH_NUM = 3;
  localparam int unsigned CH_RED = 0;
  localparam int unsigned CH_GREEN = 1;
  localparam int unsigned CH_BLUE = 2;

  localparam int unsigned REC_NUM = 3;
  localparam int unsigned REC_BAT = 0;
  localparam int unsigned REC_NOTIF = 1;
  localparam int unsigned REC_ATTN = 2;

  localparam logic [1:0] MODE_BATTERY = 2'd0;
  localparam logic [1:0] MODE_NOTIF = 2'd1;
  localparam logic [1:0] MODE_ATTN = 2'd2;

  localparam logic [1:0] KIND_STEADY = 2'd0;
  localparam logic [1:0] KIND_TIMED = 2'd1;
  localparam logic [1:0] KIND_HARDWARE = 2'd2;

  localparam logic [1:0] SRC_NONE = 2'd0;
  localparam logic [1:0] SRC_NOTIF = 2'd1;
  localparam logic [1:0] SRC_ATTN = 2'd2;
  localparam logic [1:0] SRC_BAT = 2'd3;

  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_RED = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_GREEN = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_BLUE = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_LEVEL_NOTIF = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_LEVEL_ATTN = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_LEVEL_BAT = 3'd5;

  localparam logic [15:0] GAIN_RESET = 16'd256;
  localparam logic [7:0] LEVEL_RESET = 8'd255;

  localparam logic [23:0] ATTN_HW_COLOR = 24'h0000ff;

  // floor(x / 255) for x up to 65280 * 255: (x * RECIP_255) >> RECIP_SHIFT is low by at most one
  localparam logic [15:0] RECIP_255 = 16'h8080;
  localparam int unsigned RECIP_SHIFT = 23;
  localparam logic [24:0] DIV_CONST = 25'd255;

  localparam int unsigned IN_DATA_W = 56;
  localparam int unsigned IN_USER_W = 4;
  localparam int unsigned OUT_DATA_W = 64;
  localparam int unsigned OUT_USER_W = 3;

  typedef struct packed {
    logic [23:0] color;
    logic [1:0]  kind;
    logic [15:0] on_ms;
    logic [15:0] off_ms;
  } req_t;

  typedef struct packed {
    logic upd;
    logic sel;
    logic mul1;
    logic mul2;
    logic div;
    logic corr;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic out_full;
  } sts_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SEL,
    ST_MUL1,
    ST_MUL2,
    ST_DIV,
    ST_CORR,
    ST_DONE
  } state_e;

endpackage

[rtl/nlpm_ctrl.sv]
// sequencer of the notification led priority mixer
// depends on nlpm_pkg, drives the datapath through cmd_t and reads sts_t
module nlpm_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  logic          out_ready_i,
  input  nlpm_pkg::sts_t sts_i,
  output nlpm_pkg::cmd_t cmd_o
);
  import nlpm_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.upd = 1'b1;
          state_d = ST_SEL;
        end
      end
      ST_SEL: begin
        cmd_o.sel = 1'b1;
        state_d = ST_MUL1;
      end
      ST_MUL1: begin
        cmd_o.mul1 = 1'b1;
        state_d = ST_MUL2;
      end
      ST_MUL2: begin
        cmd_o.mul2 = 1'b1;
        state_d = ST_DIV;
      end
      ST_DIV: begin
        cmd_o.div = 1'b1;
        state_d = ST_CORR;
      end
      ST_CORR: begin
        cmd_o.corr = 1'b1;
        state_d = ST_DONE;
      end
      ST_DONE: begin
        if (!sts_i.out_full || out_ready_i) begin
          cmd_o.load_out = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

[rtl/nlpm_datapath.sv]
// request store, configuration registers, priority select and calibration lanes
// depends on nlpm_pkg, sequenced by nlpm_ctrl
module nlpm_datapath (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  nlpm_pkg::cmd_t                    cmd_i,
  output nlpm_pkg::sts_t                    sts_o,
  input  logic [1:0]                        mode_i,
  input  logic [1:0]                        kind_i,
  input  logic [23:0]                       rgb_i,
  input  logic [15:0]                       on_i,
  input  logic [15:0]                       off_i,
  input  logic                              cfg_we_i,
  input  logic [nlpm_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [nlpm_pkg::CFG_DATA_W-1:0]   cfg_wdata_i,
  input  logic                              out_ready_i,
  output logic                              out_valid_o,
  output logic [nlpm_pkg::OUT_DATA_W-1:0]   out_data_o,
  output logic [nlpm_pkg::OUT_USER_W-1:0]   out_user_o
);
  import nlpm_pkg::*;

  logic [15:0] gain_q [CH_NUM];
  logic [7:0]  lvl_notif_q, lvl_attn_q, lvl_bat_q;
  req_t        rec_q [REC_NUM];
  req_t        rec_new;

  logic [23:0] sel_color, color_q;
  logic [1:0]  sel_kind;
  logic [15:0] sel_on, sel_off, on_q, off_q;
  logic [7:0]  sel_lvl, lvl_q;
  logic [1:0]  sel_src, src_q;

  logic [23:0] mul_a [CH_NUM];
  logic [15:0] mul_b [CH_NUM];
  logic [39:0] prod [CH_NUM];
  logic [24:0] rem [CH_NUM];
  logic [15:0] v_d [CH_NUM];
  logic [15:0] s_q [CH_NUM];
  logic [23:0] x_q [CH_NUM];
  logic [15:0] q_q [CH_NUM];
  logic [15:0] v_q [CH_NUM];

  logic [31:0] word;
  logic        bln;

  logic                  out_valid_q, out_valid_d;
  logic [OUT_DATA_W-1:0] out_data_q;
  logic [OUT_USER_W-1:0] out_user_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_q <= '{default: GAIN_RESET};
      lvl_notif_q <= LEVEL_RESET;
      lvl_attn_q <= LEVEL_RESET;
      lvl_bat_q <= LEVEL_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_GAIN_RED:    gain_q[CH_RED] <= cfg_wdata_i;
        REG_GAIN_GREEN:  gain_q[CH_GREEN] <= cfg_wdata_i;
        REG_GAIN_BLUE:   gain_q[CH_BLUE] <= cfg_wdata_i;
        REG_LEVEL_NOTIF: lvl_notif_q <= cfg_wdata_i[7:0];
        REG_LEVEL_ATTN:  lvl_attn_q <= cfg_wdata_i[7:0];
        REG_LEVEL_BAT:   lvl_bat_q <= cfg_wdata_i[7:0];
        default: ;
      endcase
    end
  end

  assign rec_new = '{color: rgb_i, kind: kind_i, on_ms: on_i, off_ms: off_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rec_q <= '{default: '0};
    end else if (cmd_i.upd) begin
      case (mode_i)
        MODE_BATTERY: rec_q[REC_BAT] <= rec_new;
        MODE_NOTIF:   rec_q[REC_NOTIF] <= rec_new;
        MODE_ATTN:    rec_q[REC_ATTN] <= rec_new;
        default: ;
      endcase
    end
  end

  // priority: notification, attention, battery
  always_comb begin
    sel_color = '0;
    sel_kind = KIND_STEADY;
    sel_on = '0;
    sel_off = '0;
    sel_lvl = '0;
    sel_src = SRC_NONE;
    if (|rec_q[REC_NOTIF].color) begin
      sel_color = rec_q[REC_NOTIF].color;
      sel_kind = rec_q[REC_NOTIF].kind;
      sel_on = rec_q[REC_NOTIF].on_ms;
      sel_off = rec_q[REC_NOTIF].off_ms;
      sel_lvl = lvl_notif_q;
      sel_src = SRC_NOTIF;
    end else if (|rec_q[REC_ATTN].color) begin
      sel_color = rec_q[REC_ATTN].color;
      sel_kind = rec_q[REC_ATTN].kind;
      sel_on = rec_q[REC_ATTN].on_ms;
      sel_off = rec_q[REC_ATTN].off_ms;
      sel_lvl = lvl_attn_q;
      sel_src = SRC_ATTN;
      if (sel_kind == KIND_HARDWARE) begin
        if (sel_on != '0 && sel_off == '0) begin
          sel_kind = KIND_STEADY;
        end
        sel_color = ATTN_HW_COLOR;
      end
      if (sel_kind == KIND_STEADY) begin
        sel_color = '0;
      end
    end else if (|rec_q[REC_BAT].color) begin
      sel_color = rec_q[REC_BAT].color;
      sel_kind = rec_q[REC_BAT].kind;
      sel_on = rec_q[REC_BAT].on_ms;
      sel_off = rec_q[REC_BAT].off_ms;
      sel_lvl = lvl_bat_q;
      sel_src = SRC_BAT;
    end
    if (sel_kind == KIND_STEADY) begin
      sel_on = '0;
      sel_off = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.sel) begin
      color_q <= sel_color;
      on_q <= sel_on;
      off_q <= sel_off;
      lvl_q <= sel_lvl;
      src_q <= sel_src;
    end
  end

  // one multiplier per channel, shared by gain, level and reciprocal steps
  always_comb begin
    for (int ch = 0; ch < CH_NUM; ch++) begin
      if (cmd_i.mul1) begin
        mul_a[ch] = {16'b0, color_q[8*(CH_NUM-1-ch) +: 8]};
        mul_b[ch] = gain_q[ch];
      end else if (cmd_i.mul2) begin
        mul_a[ch] = {8'b0, s_q[ch]};
        mul_b[ch] = {8'b0, lvl_q};
      end else begin
        mul_a[ch] = x_q[ch];
        mul_b[ch] = RECIP_255;
      end
      prod[ch] = {16'b0, mul_a[ch]} * {24'b0, mul_b[ch]};
      rem[ch] = {1'b0, x_q[ch]} - ({1'b0, q_q[ch], 8'b0} - {9'b0, q_q[ch]});
      v_d[ch] = (rem[ch] >= DIV_CONST) ? q_q[ch] + 16'd1 : q_q[ch];
    end
  end

  always_ff @(posedge clk_i) begin
    for (int ch = 0; ch < CH_NUM; ch++) begin
      if (cmd_i.mul1) begin
        s_q[ch] <= prod[ch][23:8];
      end
      if (cmd_i.mul2) begin
        x_q[ch] <= prod[ch][23:0];
      end
      if (cmd_i.div) begin
        q_q[ch] <= prod[ch][RECIP_SHIFT+15:RECIP_SHIFT];
      end
      if (cmd_i.corr) begin
        v_q[ch] <= v_d[ch];
      end
    end
  end

  // channels may exceed eight bits and overlap by addition
  assign word = {v_q[CH_RED], 16'b0} + {8'b0, v_q[CH_GREEN], 8'b0} + {16'b0, v_q[CH_BLUE]};
  assign bln = (src_q == SRC_NOTIF) && (|word[23:0]);

  assign out_valid_d = cmd_i.load_out | (out_valid_q & ~out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      out_data_q <= {off_q, on_q, word};
      out_user_q <= {bln, src_q};
    end
  end

  assign sts_o.out_full = out_valid_q;
  assign out_valid_o = out_valid_q;
  assign out_data_o = out_data_q;
  assign out_user_o = out_user_q;

endmodule

[rtl/notification_led_priority_mixer_core.sv]
// top level of the notification led priority mixer
// depends on nlpm_pkg, nlpm_ctrl and nlpm_datapath
//
// Each accepted word replaces one of three light requests (battery, notification,
// attention) unless its mode is 3, and yields exactly one result word with the shown
// request, its calibrated led word and its blink times. An input word is taken in
// the idle state; its result is registered after the priority select, the
// per-channel multiplier that is used three times in turn (gain, brightness,
// reciprocal of 255) and the quotient correction step. The input is taken again
// as soon as the result sits in the output register; a further result waits in its
// last step while the previous one is not yet taken. Configuration writes apply
// from the next cycle.
module notification_led_priority_mixer_core (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // rgb_color[23:0], on_time_ms[39:24], off_time_ms[55:40]
  input  logic [nlpm_pkg::IN_DATA_W-1:0]    s_axis_tdata,
  // mode[1:0], flash_kind[3:2]
  input  logic [nlpm_pkg::IN_USER_W-1:0]    s_axis_tuser,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // led_word[31:0], blink_on_ms[47:32], blink_off_ms[63:48]
  output logic [nlpm_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
  // source[1:0], bln_enable[2]
  output logic [nlpm_pkg::OUT_USER_W-1:0]   m_axis_tuser,
  input  logic                              cfg_we_i,
  input  logic [nlpm_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [nlpm_pkg::CFG_DATA_W-1:0]   cfg_wdata_i
);
  import nlpm_pkg::*;

  cmd_t cmd;
  sts_t sts;

  nlpm_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_ready_i (m_axis_tready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  nlpm_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .mode_i      (s_axis_tuser[1:0]),
    .kind_i      (s_axis_tuser[3:2]),
    .rgb_i       (s_axis_tdata[23:0]),
    .on_i        (s_axis_tdata[39:24]),
    .off_i       (s_axis_tdata[55:40]),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .out_ready_i (m_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_data_o  (m_axis_tdata),
    .out_user_o  (m_axis_tuser)
  );

endmodule

[rtl/nlpm_checker.sv]
// port-level assertions for the notification led priority mixer, bound to the top
// depends on nlpm_pkg and notification_led_priority_mixer_core_macros.svh
`include "notification_led_priority_mixer_core_macros.svh"

module nlpm_checker (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              s_axis_tvalid,
  input logic                              s_axis_tready,
  input logic                              m_axis_tvalid,
  input logic                              m_axis_tready,
  input logic [nlpm_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
  input logic [nlpm_pkg::OUT_USER_W-1:0]   m_axis_tuser
);
  import nlpm_pkg::*;

  `NLPM_ASSERT_ALWAYS(a_no_out_in_reset, !rst_ni |-> !m_axis_tvalid, "result valid in reset")
  `NLPM_ASSERT(a_out_hold, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid, "result dropped")
  `NLPM_ASSERT(a_busy_after_take, s_axis_tvalid && s_axis_tready |=> !s_axis_tready, "ready while busy")
  `NLPM_ASSERT(a_bln_notif, m_axis_tvalid && m_axis_tuser[2] |-> m_axis_tuser[1:0] == SRC_NOTIF, "blink enable without notification")
  `NLPM_ASSERT(a_off_zero, m_axis_tvalid && m_axis_tuser[1:0] == SRC_NONE |-> m_axis_tdata == '0, "nonzero result when off")

endmodule

bind notification_led_priority_mixer_core nlpm_checker u_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

[tb/sv/notification_led_priority_mixer_core_tb.sv]
// self-checking testbench for notification_led_priority_mixer_core
// depends on nlpm_pkg and the core rtl; stream driver and monitor with an
// in-bench light request mixer that predicts every result word
module notification_led_priority_mixer_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import nlpm_pkg::*;

  localparam logic [1:0] MODE_NONE = 2'd3;
  localparam logic [1:0] KIND_RESERVED = 2'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 3'd7;
  localparam int unsigned LONG_HOLD = 80;
  localparam int unsigned DRAIN_PAUSE = 8;
  localparam int unsigned WATCHDOG_LIMIT = 2000;

  typedef struct packed {
    logic [1:0]  mode;
    logic [23:0] color;
    logic [1:0]  kind;
    logic [15:0] on_ms;
    logic [15:0] off_ms;
  } light_cmd_t;

  typedef struct packed {
    logic [31:0] led_word;
    logic [15:0] on_ms;
    logic [15:0] off_ms;
    logic [1:0]  source;
    logic        bln;
  } led_out_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
  logic [IN_USER_W-1:0]  s_axis_tuser = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic [OUT_USER_W-1:0] m_axis_tuser;
  logic                  cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata_i = '0;

  // mixer state as the bench sees it
  req_t        req_store [REC_NUM] = '{default: '0};
  logic [15:0] gain_red = GAIN_RESET;
  logic [15:0] gain_green = GAIN_RESET;
  logic [15:0] gain_blue = GAIN_RESET;
  logic [7:0]  lvl_notif = LEVEL_RESET;
  logic [7:0]  lvl_attn = LEVEL_RESET;
  logic [7:0]  lvl_bat = LEVEL_RESET;

  light_cmd_t  light_cmd_q [$];
  led_out_t    led_expect_q [$];
  light_cmd_t  cmd_on_bus;
  int unsigned n_queued = 0;
  int unsigned n_taken = 0;
  int unsigned send_gap = 0;
  int unsigned rcv_stall = 0;
  int unsigned hold_asked = 0;
  int unsigned hold_taken = 0;
  int unsigned idle_cycles = 0;
  int unsigned err_cnt = 0;
  bit          calm = 1'b0;

  notification_led_priority_mixer_core dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  function automatic logic [31:0] chan_scale(logic [7:0] c, logic [15:0] g, logic [7:0] l);
    logic [31:0] s;
    s = (32'(c) * 32'(g)) >> 8;
    return (s * 32'(l)) / 32'd255;
  endfunction

  function automatic led_out_t mix_request(light_cmd_t c);
    req_t       pick;
    logic [7:0] lvl;
    led_out_t   o;
    o = '0;
    pick = '0;
    lvl = '0;
    if (c.mode != MODE_NONE)
      req_store[c.mode] = '{color: c.color, kind: c.kind, on_ms: c.on_ms, off_ms: c.off_ms};
    if (req_store[REC_NOTIF].color != '0) begin
      pick = req_store[REC_NOTIF];
      lvl = lvl_notif;
      o.source = SRC_NOTIF;
    end else if (req_store[REC_ATTN].color != '0) begin
      pick = req_store[REC_ATTN];
      lvl = lvl_attn;
      o.source = SRC_ATTN;
      if (pick.kind == KIND_HARDWARE) begin
        if (pick.on_ms != '0 && pick.off_ms == '0) pick.kind = KIND_STEADY;
        pick.color = ATTN_HW_COLOR;
      end
      if (pick.kind == KIND_STEADY) pick.color = '0;
    end else if (req_store[REC_BAT].color != '0) begin
      pick = req_store[REC_BAT];
      lvl = lvl_bat;
      o.source = SRC_BAT;
    end
    if (o.source != SRC_NONE) begin
      if (pick.kind == KIND_STEADY) begin
        pick.on_ms = '0;
        pick.off_ms = '0;
      end
      o.led_word = (chan_scale(pick.color[23:16], gain_red, lvl) << 16)
                 + (chan_scale(pick.color[15:8], gain_green, lvl) << 8)
                 + chan_scale(pick.color[7:0], gain_blue, lvl);
      o.on_ms = pick.on_ms;
      o.off_ms = pick.off_ms;
      if (o.source == SRC_NOTIF) o.bln = |o.led_word[23:0];
    end
    return o;
  endfunction

  function automatic logic [15:0] pick_ms();
    case ($urandom_range(0, 3))
      0: return '0;
      1: return 16'hffff;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic queue_cmd(input light_cmd_t c);
    light_cmd_q.insert(light_cmd_q.size(), c);
    n_queued++;
  endtask

  task automatic queue_random(input int unsigned n);
    light_cmd_t c;
    repeat (n) begin
      c.mode = ($urandom_range(0, 11) == 0) ? MODE_NONE : 2'($urandom_range(0, 2));
      case ($urandom_range(0, 7))
        0, 1, 2: c.color = '0;
        3: c.color = 24'hffffff;
        4: c.color = 24'($urandom_range(1, 255)) << (8 * $urandom_range(0, 2));
        default: c.color = 24'($urandom);
      endcase
      c.kind = 2'($urandom_range(0, 3));
      c.on_ms = pick_ms();
      c.off_ms = pick_ms();
      queue_cmd(c);
    end
  endtask

  task automatic wait_drained();
    while (n_taken != n_queued || led_expect_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_PAUSE) @(posedge clk_i);
  endtask

  task automatic apply_settings(input logic [15:0] gr, gg, gb, ln, la, lb);
    logic [CFG_IDX_W-1:0] regs [8];
    logic [15:0]          vals [8];
    regs = '{REG_GAIN_RED, REG_GAIN_GREEN, REG_GAIN_BLUE, REG_LEVEL_NOTIF,
             REG_LEVEL_ATTN, REG_LEVEL_BAT, REG_SPARE_A, REG_SPARE_B};
    vals = '{gr, gg, gb, ln, la, lb, 16'($urandom), 16'($urandom)};
    for (int i = 0; i < 8; i++) begin
      @(posedge clk_i);
      cfg_we_i <= 1'b1;
      cfg_idx_i <= regs[i];
      cfg_wdata_i <= vals[i];
    end
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    gain_red = gr;
    gain_green = gg;
    gain_blue = gb;
    lvl_notif = ln[7:0];
    lvl_attn = la[7:0];
    lvl_bat = lb[7:0];
  endtask

  task automatic field_check(input string fname, input logic [31:0] want, got);
    if (want !== got) begin
      $display("%0t %s expected %h actual %h", $time, fname, want, got);
      err_cnt++;
    end
  endtask

  // word driver
  always @(posedge clk_i) begin
    if (rst_ni && s_axis_tvalid && s_axis_tready) begin
      led_expect_q.insert(led_expect_q.size(), mix_request(cmd_on_bus));
      n_taken++;
    end
    if (!s_axis_tvalid || s_axis_tready) begin
      if (send_gap > 0) begin
        send_gap--;
        s_axis_tvalid <= 1'b0;
      end else if (rst_ni && light_cmd_q.size() > 0) begin
        cmd_on_bus = light_cmd_q.pop_front();
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {cmd_on_bus.off_ms, cmd_on_bus.on_ms, cmd_on_bus.color};
        s_axis_tuser <= {cmd_on_bus.kind, cmd_on_bus.mode};
        if (!calm && $urandom_range(0, 3) == 0) send_gap = $urandom_range(1, 3);
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // receiver back-pressure
  always @(posedge clk_i) begin
    if (rcv_stall > 0) begin
      rcv_stall--;
      m_axis_tready <= 1'b0;
    end else if (hold_taken != hold_asked) begin
      hold_taken++;
      rcv_stall = LONG_HOLD - 1;
      m_axis_tready <= 1'b0;
    end else if (!calm && $urandom_range(0, 5) == 0) begin
      rcv_stall = $urandom_range(0, 2);
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // result monitor
  always @(posedge clk_i) begin : result_mon
    led_out_t got;
    led_out_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = '{led_word: m_axis_tdata[31:0], on_ms: m_axis_tdata[47:32],
              off_ms: m_axis_tdata[63:48], source: m_axis_tuser[1:0],
              bln: m_axis_tuser[2]};
      if (led_expect_q.size() == 0) begin
        $display("%0t unexpected word expected none actual %h", $time, got);
        err_cnt++;
      end else begin
        want = led_expect_q.pop_front();
        field_check("led_word", want.led_word, got.led_word);
        field_check("blink_on_ms", 32'(want.on_ms), 32'(got.on_ms));
        field_check("blink_off_ms", 32'(want.off_ms), 32'(got.off_ms));
        field_check("source", 32'(want.source), 32'(got.source));
        field_check("bln_enable", 32'(want.bln), 32'(got.bln));
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  initial begin
    rst_ni <= 1'b0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset settings, priority and flash special cases
    queue_cmd(light_cmd_t'{MODE_NONE, 24'hffffff, KIND_TIMED, 16'hffff, 16'hffff});
    queue_cmd(light_cmd_t'{MODE_BATTERY, 24'hffffff, KIND_STEADY, 16'hffff, 16'hffff});
    queue_cmd(light_cmd_t'{MODE_BATTERY, 24'h010203, KIND_TIMED, 16'd1, 16'd2});
    queue_cmd(light_cmd_t'{MODE_ATTN, 24'h123456, KIND_HARDWARE, 16'd100, 16'd0});
    queue_cmd(light_cmd_t'{MODE_ATTN, 24'h654321, KIND_HARDWARE, 16'd100, 16'd50});
    queue_cmd(light_cmd_t'{MODE_ATTN, 24'h000001, KIND_HARDWARE, 16'd0, 16'd0});
    queue_cmd(light_cmd_t'{MODE_ATTN, 24'hff0000, KIND_STEADY, 16'd300, 16'd400});
    queue_cmd(light_cmd_t'{MODE_ATTN, 24'hff00ff, KIND_TIMED, 16'd500, 16'd500});
    queue_cmd(light_cmd_t'{MODE_ATTN, 24'h123456, KIND_RESERVED, 16'hffff, 16'd1});
    queue_cmd(light_cmd_t'{MODE_NOTIF, 24'hffffff, KIND_TIMED, 16'hffff, 16'hffff});
    queue_cmd(light_cmd_t'{MODE_NOTIF, 24'h000001, KIND_RESERVED, 16'd0, 16'hffff});
    queue_cmd(light_cmd_t'{MODE_NOTIF, 24'h800000, KIND_STEADY, 16'd7, 16'd9});
    queue_cmd(light_cmd_t'{MODE_NOTIF, 24'h0000ff, KIND_HARDWARE, 16'd10, 16'd0});
    queue_cmd(light_cmd_t'{MODE_NONE, 24'h000000, KIND_STEADY, 16'd0, 16'd0});
    queue_cmd(light_cmd_t'{MODE_NOTIF, 24'h000000, KIND_TIMED, 16'd5, 16'd5});
    queue_cmd(light_cmd_t'{MODE_ATTN, 24'h000000, KIND_TIMED, 16'd1, 16'd1});
    queue_cmd(light_cmd_t'{MODE_BATTERY, 24'h00ff00, KIND_HARDWARE, 16'd1234, 16'd0});
    queue_cmd(light_cmd_t'{MODE_BATTERY, 24'h000000, KIND_TIMED, 16'hffff, 16'hffff});
    queue_random(60);
    wait_drained();

    // full gain, receiver holds off while words keep coming
    apply_settings(16'hffff, 16'hffff, 16'hffff, 16'd255, 16'd255, 16'd255);
    queue_random(80);
    hold_asked++;
    wait_drained();

    apply_settings(16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
    queue_random(40);
    wait_drained();

    // red overflow into bit 24 leaves the low color bits clear
    apply_settings(16'd512, 16'd0, 16'd0, 16'd255, 16'd255, 16'd255);
    queue_cmd(light_cmd_t'{MODE_NOTIF, 24'h800000, KIND_TIMED, 16'd20, 16'd30});
    queue_random(40);
    wait_drained();

    apply_settings(16'($urandom), 16'($urandom), 16'($urandom),
                   16'($urandom), 16'($urandom), 16'($urandom));
    queue_random(120);
    wait_drained();

    apply_settings(GAIN_RESET, GAIN_RESET, GAIN_RESET, 16'd1, 16'd128, 16'd200);
    queue_random(100);
    wait_drained();

    calm = 1'b1;
    apply_settings(16'($urandom_range(0, 1024)), 16'($urandom_range(0, 1024)),
                   16'($urandom_range(0, 1024)), 16'($urandom_range(0, 255)),
                   16'($urandom_range(0, 255)), 16'($urandom_range(0, 255)));
    queue_random(110);
    wait_drained();
    repeat (20) @(posedge clk_i);

    if (err_cnt == 0 && led_expect_q.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

[files.f]
+incdir+rtl
rtl/nlpm_pkg.sv
rtl/nlpm_ctrl.sv
rtl/nlpm_datapath.sv
rtl/notification_led_priority_mixer_core.sv
rtl/nlpm_checker.sv
tb/sv/notification_led_priority_mixer_core_tb.sv
